[hdl/imu_scale_and_gyro_bias_calibration_macros.svh]
// Assertion macros shared by the IMU scale and calibration RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef IMU_SCALE_AND_GYRO_BIAS_CALIBRATION_MACROS_SVH
`define IMU_SCALE_AND_GYRO_BIAS_CALIBRATION_MACROS_SVH

// same-cycle implication, disabled in reset
`define IMU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define IMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/imu_cal_pkg.sv]
// Package for the IMU scale and rotation-bias calibration block.
// Widths, register indexes, status struct and 24-bit clip helpers.
// No dependencies.
package imu_cal_pkg;

  localparam int OUT_FRAC_BITS = 12;
  localparam int SAMPLE_BITS   = 16;
  localparam int OUT_W         = 24;
  localparam int SUM_W         = 40;
  localparam int QUO_W         = SUM_W + 1;
  localparam int CFG_W         = 16;
  localparam int MUL_W         = 18;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int WIDE_W        = 42;
  localparam int DIV_CNT_W     = $clog2(SUM_W);
  localparam int N_VALS        = 7;
  localparam int N_AXES        = 3;

  localparam int TEMP_RECIP_Q24 = 126640;
  localparam int TEMP_OFFSET    = 25;
  localparam int TEMP_SH        = 24 - OUT_FRAC_BITS;
  localparam int GAIN_SH        = 16 - OUT_FRAC_BITS;

  typedef logic signed [OUT_W-1:0] out_val_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CFG_W-1:0]        cfg_word_t;
  typedef logic [1:0]              cfg_idx_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam cfg_idx_t REG_CALIB_COUNT = 2'd0;
  localparam cfg_idx_t REG_ACCEL_GAIN  = 2'd1;
  localparam cfg_idx_t REG_GYRO_GAIN   = 2'd2;

  localparam cfg_word_t CALIB_COUNT_RST = 16'd1;
  localparam cfg_word_t ACCEL_GAIN_RST  = 16'd16;
  localparam cfg_word_t GYRO_GAIN_RST   = 16'd3996;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic clip_ovf(input wide_t v);
    return !((&v[WIDE_W-1:OUT_W-1]) || ~(|v[WIDE_W-1:OUT_W-1]));
  endfunction

  function automatic out_val_t clip_out(input wide_t v);
    out_val_t r;
    if (clip_ovf(v)) begin
      r = v[WIDE_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/imu_cal_div.sv]
// Restoring serial divider: signed 40-bit sum by unsigned 16-bit count.
// One quotient bit per cycle, truncates toward zero. Uses imu_cal_pkg.
`include "imu_scale_and_gyro_bias_calibration_macros.svh"
module imu_cal_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  imu_cal_pkg::sum_t         dividend,
  input  imu_cal_pkg::cfg_word_t    divisor,
  output imu_cal_pkg::div_status_t  status,
  output logic signed [imu_cal_pkg::QUO_W-1:0] quotient
);
  import imu_cal_pkg::*;

  logic [SUM_W-1:0]     quo_r;
  logic [CFG_W-1:0]     rem_r;
  logic [CFG_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 done_r;

  logic [SUM_W-1:0] mag;
  logic [CFG_W:0]   shifted;
  logic [CFG_W+1:0] trial;
  logic signed [QUO_W-1:0] quo_pos;

  assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign quo_pos = $signed({1'b0, quo_r});
  assign quotient = neg_r ? -quo_pos : quo_pos;

  assign status.busy = busy_r;
  assign status.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= mag;
        rem_r  <= '0;
        dvs_r  <= divisor;
        neg_r  <= dividend[SUM_W-1];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= trial[CFG_W+1] ? shifted[CFG_W-1:0] : trial[CFG_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], ~trial[CFG_W+1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  `IMU_ASSERT_IMPL(a_start_idle, clk, rst_n, start, !busy_r, "divider restarted while busy")
  `IMU_ASSERT_IMPL(a_done_after_busy, clk, rst_n, done_r, $past(busy_r), "done without run")
  `IMU_ASSERT_NEXT(a_busy_holds, clk, rst_n, busy_r && (cnt_r != DIV_CNT_W'(SUM_W - 1)),
                   busy_r, "divider stopped early")

endmodule

[hdl/imu_scale_and_gyro_bias_calibration.sv]
// Each item runs ST_MUL/ST_POST per value, ST_ACC per axis, ST_OUT; inputs wait for ST_IDLE.
// A calibration item that completes the average adds 3 serial divides before ST_OUT.
// Rate is set by one shared 18x18 multiplier used for 7 products, plus a 3-step add/subtract.
// The output register lets a new item start while the previous result waits.
// Reset (rst_n low, synchronous): config to defaults, sums, count and bias to zero.
`include "imu_scale_and_gyro_bias_calibration_macros.svh"
module imu_scale_and_gyro_bias_calibration (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  imu_cal_pkg::cfg_idx_t   cfg_index,
  input  imu_cal_pkg::cfg_word_t  cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic signed [15:0]      in_temp_sample,
  input  logic signed [15:0]      in_accel_x_sample,
  input  logic signed [15:0]      in_accel_y_sample,
  input  logic signed [15:0]      in_accel_z_sample,
  input  logic signed [15:0]      in_rate_x_sample,
  input  logic signed [15:0]      in_rate_y_sample,
  input  logic signed [15:0]      in_rate_z_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output imu_cal_pkg::out_val_t   out_temp_celsius,
  output imu_cal_pkg::out_val_t   out_accel_x_g,
  output imu_cal_pkg::out_val_t   out_accel_y_g,
  output imu_cal_pkg::out_val_t   out_accel_z_g,
  output imu_cal_pkg::out_val_t   out_rate_x_dps,
  output imu_cal_pkg::out_val_t   out_rate_y_dps,
  output imu_cal_pkg::out_val_t   out_rate_z_dps,
  output logic                    out_calib_done,
  output logic                    out_saturated
);
  import imu_cal_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POST,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  state_t state_r;

  cfg_word_t calib_count_r;
  cfg_word_t accel_gain_r;
  cfg_word_t gyro_gain_r;

  logic [SAMPLE_BITS-1:0] samp_r [N_VALS];
  out_val_t               res_r  [N_VALS];
  sum_t                   sums_r [N_AXES];
  out_val_t               bias_r [N_AXES];
  logic [CFG_W-1:0]       seen_r;
  logic [2:0]             idx_r;
  logic [1:0]             ax_r;
  logic                   cmd_r;
  logic                   sat_r;
  logic                   done_r;
  logic signed [PROD_W-1:0] prod_r;

  logic     out_valid_r;
  out_val_t out_val_r [N_VALS];
  logic     out_done_r;
  logic     out_sat_r;

  logic signed [SAMPLE_BITS-1:0] samp_sx;
  logic signed [MUL_W-1:0]       op_a;
  logic signed [MUL_W-1:0]       op_b;
  logic signed [PROD_W-1:0]      prod_nxt;
  wide_t                         post_val;
  logic [2:0]                    ridx;
  out_val_t                      rate_sel;
  sum_t                          sum_nxt;
  wide_t                         diff;
  cfg_word_t                     cnt_eff;
  logic [CFG_W-1:0]              seen_nxt;
  logic                          in_xfer;
  logic                          out_free;
  logic                          div_start;
  div_status_t                   div_st;
  logic signed [QUO_W-1:0]       div_quo;
  wide_t                         quo_w;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign samp_sx = $signed(samp_r[idx_r]);
  assign op_a    = MUL_W'(samp_sx);

  always_comb begin
    if (idx_r == 3'd0) begin
      op_b = MUL_W'(TEMP_RECIP_Q24);
    end else if (idx_r < 3'd4) begin
      op_b = $signed(MUL_W'({1'b0, accel_gain_r}));
    end else begin
      op_b = $signed(MUL_W'({1'b0, gyro_gain_r}));
    end
  end

  assign prod_nxt = op_a * op_b;

  always_comb begin
    if (idx_r == 3'd0) begin
      post_val = WIDE_W'(prod_r >>> TEMP_SH) + WIDE_W'(TEMP_OFFSET << OUT_FRAC_BITS);
    end else begin
      post_val = WIDE_W'(prod_r >>> GAIN_SH);
    end
  end

  assign ridx     = 3'(ax_r) + 3'd4;
  assign rate_sel = res_r[ridx];
  assign sum_nxt  = sums_r[ax_r] + SUM_W'(rate_sel);
  assign diff     = WIDE_W'(rate_sel) - WIDE_W'(bias_r[ax_r]);
  assign cnt_eff  = (calib_count_r == '0) ? CALIB_COUNT_RST : calib_count_r;
  assign seen_nxt = seen_r + 1'b1;
  assign div_start = (state_r == ST_DIV_START);
  assign quo_w    = WIDE_W'(div_quo);

  imu_cal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sums_r[ax_r]),
    .divisor  (cnt_eff),
    .status   (div_st),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      calib_count_r <= CALIB_COUNT_RST;
      accel_gain_r  <= ACCEL_GAIN_RST;
      gyro_gain_r   <= GYRO_GAIN_RST;
      seen_r        <= '0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      ax_r          <= '0;
      for (int i = 0; i < N_AXES; i++) begin
        sums_r[i] <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CALIB_COUNT: calib_count_r <= cfg_data;
          REG_ACCEL_GAIN:  accel_gain_r  <= cfg_data;
          REG_GYRO_GAIN:   gyro_gain_r   <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            samp_r[0] <= in_temp_sample[SAMPLE_BITS-1:0];
            samp_r[1] <= in_accel_x_sample[SAMPLE_BITS-1:0];
            samp_r[2] <= in_accel_y_sample[SAMPLE_BITS-1:0];
            samp_r[3] <= in_accel_z_sample[SAMPLE_BITS-1:0];
            samp_r[4] <= in_rate_x_sample[SAMPLE_BITS-1:0];
            samp_r[5] <= in_rate_y_sample[SAMPLE_BITS-1:0];
            samp_r[6] <= in_rate_z_sample[SAMPLE_BITS-1:0];
            cmd_r     <= in_command;
            sat_r     <= 1'b0;
            done_r    <= 1'b0;
            idx_r     <= '0;
            state_r   <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_POST;
        end
        ST_POST: begin
          res_r[idx_r] <= clip_out(post_val);
          sat_r        <= sat_r | clip_ovf(post_val);
          if (idx_r == 3'(N_VALS - 1)) begin
            idx_r   <= '0;
            ax_r    <= '0;
            state_r <= ST_ACC;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_ACC: begin
          if (cmd_r) begin
            sums_r[ax_r] <= sum_nxt;
          end else begin
            res_r[ridx] <= clip_out(diff);
            sat_r       <= sat_r | clip_ovf(diff);
          end
          if (ax_r == 2'(N_AXES - 1)) begin
            ax_r <= '0;
            if (cmd_r && (seen_nxt >= cnt_eff)) begin
              seen_r  <= '0;
              state_r <= ST_DIV_START;
            end else begin
              if (cmd_r) begin
                seen_r <= seen_nxt;
              end
              state_r <= ST_OUT;
            end
          end else begin
            ax_r <= ax_r + 1'b1;
          end
        end
        ST_DIV_START: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_st.done) begin
            bias_r[ax_r] <= clip_out(quo_w);
            sat_r        <= sat_r | clip_ovf(quo_w);
            sums_r[ax_r] <= '0;
            if (ax_r == 2'(N_AXES - 1)) begin
              ax_r    <= '0;
              done_r  <= 1'b1;
              state_r <= ST_OUT;
            end else begin
              ax_r    <= ax_r + 1'b1;
              state_r <= ST_DIV_START;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            for (int i = 0; i < N_VALS; i++) begin
              out_val_r[i] <= res_r[i];
            end
            out_done_r  <= done_r;
            out_sat_r   <= sat_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_celsius = out_val_r[0];
  assign out_accel_x_g    = out_val_r[1];
  assign out_accel_y_g    = out_val_r[2];
  assign out_accel_z_g    = out_val_r[3];
  assign out_rate_x_dps   = out_val_r[4];
  assign out_rate_y_dps   = out_val_r[5];
  assign out_rate_z_dps   = out_val_r[6];
  assign out_calib_done   = out_done_r;
  assign out_saturated    = out_sat_r;

  `IMU_ASSERT_NEXT(a_one_item, clk, rst_n, in_xfer, in_stall, "second input taken while busy")
  `IMU_ASSERT_IMPL(a_div_wait, clk, rst_n, div_st.done, state_r == ST_DIV_WAIT,
                   "divider result outside wait state")
  `IMU_ASSERT_IMPL(a_out_load, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_OUT),
                   "result loaded outside output state")

endmodule

[test/imu_scale_and_gyro_bias_calibration_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for imu_scale_and_gyro_bias_calibration: scaling, saturation,
// bias calibration and register writes, checked against a built-in scaling predictor.
// Depends on imu_cal_pkg and the block's RTL only.
module imu_scale_and_gyro_bias_calibration_tb;
  import imu_cal_pkg::*;

  localparam cfg_idx_t REG_UNMAPPED  = 2'd3;
  localparam logic     CMD_NORMAL    = 1'b0;
  localparam logic     CMD_CALIBRATE = 1'b1;
  localparam int       MAX_REPORTS   = 10;
  localparam int       DRAIN_CYCLES  = 300;

  typedef logic signed [SAMPLE_BITS-1:0] raw_t;

  typedef struct {
    logic command;
    raw_t temp;
    raw_t accel [N_AXES];
    raw_t rate  [N_AXES];
  } imu_sample_t;

  typedef struct {
    out_val_t val [N_VALS];
    bit       done;
    bit       sat;
  } imu_result_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_word_t cfg_data  = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  logic      in_command = CMD_NORMAL;
  raw_t      in_temp_sample    = '0;
  raw_t      in_accel_x_sample = '0;
  raw_t      in_accel_y_sample = '0;
  raw_t      in_accel_z_sample = '0;
  raw_t      in_rate_x_sample  = '0;
  raw_t      in_rate_y_sample  = '0;
  raw_t      in_rate_z_sample  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_val_t  out_temp_celsius, out_accel_x_g, out_accel_y_g, out_accel_z_g;
  out_val_t  out_rate_x_dps, out_rate_y_dps, out_rate_z_dps;
  logic      out_calib_done, out_saturated;

  // predictor state
  cfg_word_t               calib_count_reg = CALIB_COUNT_RST;
  cfg_word_t               accel_gain_reg  = ACCEL_GAIN_RST;
  cfg_word_t               gyro_gain_reg   = GYRO_GAIN_RST;
  logic signed [SUM_W-1:0] rate_sum [N_AXES] = '{default: '0};
  logic [15:0]             calib_seen_cnt  = '0;
  longint                  rate_bias_est [N_AXES] = '{default: 0};

  imu_result_t pending_results [$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left  = 0;
  int          stall_run      = 0;
  bit          stalling       = 1'b0;
  string       val_names [N_VALS] = '{"temp_celsius", "accel_x_g", "accel_y_g", "accel_z_g",
                                      "rate_x_dps", "rate_y_dps", "rate_z_dps"};

  imu_scale_and_gyro_bias_calibration uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_temp_sample    (in_temp_sample),
    .in_accel_x_sample (in_accel_x_sample),
    .in_accel_y_sample (in_accel_y_sample),
    .in_accel_z_sample (in_accel_z_sample),
    .in_rate_x_sample  (in_rate_x_sample),
    .in_rate_y_sample  (in_rate_y_sample),
    .in_rate_z_sample  (in_rate_z_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_temp_celsius  (out_temp_celsius),
    .out_accel_x_g     (out_accel_x_g),
    .out_accel_y_g     (out_accel_y_g),
    .out_accel_z_g     (out_accel_z_g),
    .out_rate_x_dps    (out_rate_x_dps),
    .out_rate_y_dps    (out_rate_y_dps),
    .out_rate_z_dps    (out_rate_z_dps),
    .out_calib_done    (out_calib_done),
    .out_saturated     (out_saturated)
  );

  always #5 clk = ~clk;

  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint clip_out_val(longint v, inout bit sat);
    longint hi, lo;
    hi = (longint'(1) <<< (OUT_W - 1)) - 1;
    lo = -(longint'(1) <<< (OUT_W - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Works out one result and advances the calibration state.
  function automatic imu_result_t predict_scaled_sample(imu_sample_t s);
    imu_result_t r;
    bit          sat;
    longint      t, cnt;
    longint      rate [N_AXES];
    sat = 1'b0;
    t = (longint'(s.temp) * TEMP_RECIP_Q24) >>> TEMP_SH;
    r.val[0] = out_val_t'(clip_out_val(t + (TEMP_OFFSET << OUT_FRAC_BITS), sat));
    for (int i = 0; i < N_AXES; i++) begin
      t = (longint'(s.accel[i]) * longint'(accel_gain_reg)) >>> GAIN_SH;
      r.val[1 + i] = out_val_t'(clip_out_val(t, sat));
      t = (longint'(s.rate[i]) * longint'(gyro_gain_reg)) >>> GAIN_SH;
      rate[i] = clip_out_val(t, sat);
    end
    r.done = 1'b0;
    if (s.command == CMD_CALIBRATE) begin
      cnt = (calib_count_reg == '0) ? 1 : longint'(calib_count_reg);
      for (int i = 0; i < N_AXES; i++) begin
        t = longint'(rate_sum[i]) + rate[i];
        rate_sum[i] = t[SUM_W-1:0];
      end
      calib_seen_cnt = calib_seen_cnt + 1'b1;
      if (longint'(calib_seen_cnt) >= cnt) begin
        for (int i = 0; i < N_AXES; i++) begin
          rate_bias_est[i] = clip_out_val(longint'(rate_sum[i]) / cnt, sat);
          rate_sum[i] = '0;
        end
        calib_seen_cnt = '0;
        r.done = 1'b1;
      end
    end else begin
      for (int i = 0; i < N_AXES; i++)
        rate[i] = clip_out_val(rate[i] - rate_bias_est[i], sat);
    end
    for (int i = 0; i < N_AXES; i++)
      r.val[4 + i] = out_val_t'(rate[i]);
    r.sat = sat;
    return r;
  endfunction

  function automatic raw_t pick_raw();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return raw_t'(int'($urandom_range(200)) - 100);
      default: return raw_t'($urandom);
    endcase
  endfunction

  function automatic cfg_word_t pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return cfg_word_t'($urandom);
      default: return cfg_word_t'($urandom_range(4096));
    endcase
  endfunction

  function automatic cfg_word_t pick_count();
    case ($urandom_range(9))
      0: return '0;
      1: return cfg_word_t'($urandom_range(40, 9));
      default: return cfg_word_t'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic imu_sample_t random_sample(logic cmd);
    imu_sample_t s;
    s.command = cmd;
    s.temp = pick_raw();
    for (int i = 0; i < N_AXES; i++) begin
      s.accel[i] = pick_raw();
      s.rate[i]  = pick_raw();
    end
    return s;
  endfunction

  function automatic imu_sample_t uniform_sample(logic cmd, raw_t v);
    imu_sample_t s;
    s.command = cmd;
    s.temp = v;
    for (int i = 0; i < N_AXES; i++) begin
      s.accel[i] = v;
      s.rate[i]  = v;
    end
    return s;
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: %s", $time, msg);
  endtask

  task automatic send_sample(imu_sample_t s);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(30, 1)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= s.command;
    in_temp_sample    <= s.temp;
    in_accel_x_sample <= s.accel[0];
    in_accel_y_sample <= s.accel[1];
    in_accel_z_sample <= s.accel[2];
    in_rate_x_sample  <= s.rate[0];
    in_rate_y_sample  <= s.rate[1];
    in_rate_z_sample  <= s.rate[2];
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_scaled_sample(s));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, cfg_word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CALIB_COUNT: calib_count_reg = val;
      REG_ACCEL_GAIN:  accel_gain_reg  = val;
      REG_GYRO_GAIN:   gyro_gain_reg   = val;
      default: ;
    endcase
  endtask

  // writes to the unmapped index must leave every register alone
  task automatic configure(cfg_word_t count, cfg_word_t a_gain, cfg_word_t g_gain);
    wait_idle();
    put_reg(REG_UNMAPPED, cfg_word_t'($urandom));
    put_reg(REG_CALIB_COUNT, count);
    put_reg(REG_ACCEL_GAIN, a_gain);
    put_reg(REG_GYRO_GAIN, g_gain);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stalling  = recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
        stall_run = $urandom_range(24, 1);
      end
      stall_run--;
      out_stall <= stalling;
    end
  end

  always @(posedge clk) begin
    imu_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.val[0] = out_temp_celsius;
      got.val[1] = out_accel_x_g;
      got.val[2] = out_accel_y_g;
      got.val[3] = out_accel_z_g;
      got.val[4] = out_rate_x_dps;
      got.val[5] = out_rate_y_dps;
      got.val[6] = out_rate_z_dps;
      got.done   = out_calib_done;
      got.sat    = out_saturated;
      if (pending_results.size() == 0) begin
        note_failure("result transfer with no result pending");
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < N_VALS; i++)
          if (got.val[i] !== want.val[i])
            note_failure($sformatf("%s expected %0d got %0d", val_names[i],
                                   want.val[i], got.val[i]));
        if (got.done !== want.done)
          note_failure($sformatf("calib_done expected %0b got %0b", want.done, got.done));
        if (got.sat !== want.sat)
          note_failure($sformatf("saturated expected %0b got %0b", want.sat, got.sat));
      end
    end
  end

  // reset register values, extremes of every field, calibration with count of one
  task automatic test_default_scaling();
    send_sample(uniform_sample(CMD_NORMAL, 16'sh0000));
    send_sample(uniform_sample(CMD_NORMAL, 16'sh7FFF));
    send_sample(uniform_sample(CMD_NORMAL, 16'sh8000));
    send_sample(uniform_sample(CMD_NORMAL, 16'shFFFF));
    send_sample(uniform_sample(CMD_CALIBRATE, 16'sh03E8));
    send_sample(random_sample(CMD_NORMAL));
  endtask

  // full-scale gains saturate; bias at the rails clips the subtraction; zero count acts as one
  task automatic test_gain_extremes();
    configure('0, '1, '1);
    send_sample(uniform_sample(CMD_CALIBRATE, 16'sh7FFF));
    send_sample(uniform_sample(CMD_NORMAL, 16'sh8000));
    send_sample(uniform_sample(CMD_NORMAL, 16'sh7FFF));
    send_sample(uniform_sample(CMD_CALIBRATE, 16'sh8000));
    send_sample(uniform_sample(CMD_NORMAL, 16'sh7FFF));
    configure(16'd1, '0, '0);
    send_sample(uniform_sample(CMD_NORMAL, 16'sh7FFF));
    send_sample(uniform_sample(CMD_NORMAL, 16'sh8000));
  endtask

  // count lowered below the number already seen completes on the next calibration transfer
  task automatic test_count_lowered();
    configure('1, ACCEL_GAIN_RST, GYRO_GAIN_RST);
    repeat (4) send_sample(random_sample(CMD_CALIBRATE));
    configure(16'd2, ACCEL_GAIN_RST, GYRO_GAIN_RST);
    send_sample(random_sample(CMD_CALIBRATE));
    configure(16'd3, ACCEL_GAIN_RST, GYRO_GAIN_RST);
    repeat (3) send_sample(random_sample(CMD_CALIBRATE));
    send_sample(random_sample(CMD_NORMAL));
  endtask

  // mostly complete calibration runs followed by corrected samples, plus loose commands
  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
    int        sent;
    int        run_len;
    cfg_word_t count;
    for (int seg = 0; seg < 4; seg++) begin
      count = pick_count();
      configure(count, pick_gain(), pick_gain());
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items / 4) begin
        if ($urandom_range(9) < 7) begin
          run_len = (count == '0) ? 1 : int'(count);
          repeat (run_len) send_sample(random_sample(CMD_CALIBRATE));
          repeat ($urandom_range(6, 1)) begin
            send_sample(random_sample(CMD_NORMAL));
            sent++;
          end
          sent += run_len;
        end else begin
          send_sample(random_sample($urandom_range(1) ? CMD_CALIBRATE : CMD_NORMAL));
          sent++;
        end
      end
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_input_backpressure();
    configure(16'd3, ACCEL_GAIN_RST, GYRO_GAIN_RST);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 400;
    repeat (30) send_sample(random_sample($urandom_range(1) ? CMD_CALIBRATE : CMD_NORMAL));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_default_scaling();
    test_gain_extremes();
    test_count_lowered();
    test_random_traffic(0, 0, 380);
    test_random_traffic(68, 0, 380);
    test_random_traffic(0, 68, 380);
    test_random_traffic(16, 16, 380);
    test_input_backpressure();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
